[rtl/b58enc_pkg.sv]
// Shared types, constants and the digit-to-character map of the base-58 block encoder.
`timescale 1ns / 1ps

package b58enc_pkg;

    localparam int STORE_W     = 48;   // bit store width
    localparam int FILL_W      = 6;    // bit count, 0..40
    localparam int BLOCK_BITS  = 41;
    localparam int DIGITS      = 7;    // base-58 digits per block
    localparam int DIGIT_W     = 6;
    localparam int DIG_IDX_W   = 3;
    localparam int RADIX       = 58;
    localparam int CHUNK_W     = 12;   // dividend bits taken per divide step
    localparam int CHUNKS      = 4;    // steps per divide by 58
    localparam int CHUNK_IDX_W = 2;
    localparam int QUO_W       = CHUNK_W * CHUNKS;
    localparam int PART_W      = DIGIT_W + CHUNK_W;   // partial dividend
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP       = (1 << RECIP_SHIFT) / RADIX;
    localparam int CHAR_W      = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              run_end;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;     // take the input item
        logic load_pend;  // load the padded tail block
        logic div_step;   // one divide step
        logic dig_done;   // this step finishes a digit
        logic emit;       // load one character into the output register
        logic emit_last;  // that character ends the run
    } t_dp_cmd;

    typedef struct packed {
        logic blk_go;     // the offered item starts a block
        logic pend;       // a padded tail block waits
        logic out_free;   // output register can take a character
    } t_dp_sts;

    // Map a base-58 digit to its alphabet character.
    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] c;
        dx = CHAR_W'(d);
        if (d < DIGIT_W'(9)) begin
            c = CHAR_W'(49) + dx;
        end else if (d < DIGIT_W'(17)) begin
            c = CHAR_W'(65) + dx - CHAR_W'(9);
        end else if (d < DIGIT_W'(22)) begin
            c = CHAR_W'(74) + dx - CHAR_W'(17);
        end else if (d < DIGIT_W'(33)) begin
            c = CHAR_W'(80) + dx - CHAR_W'(22);
        end else if (d < DIGIT_W'(44)) begin
            c = CHAR_W'(97) + dx - CHAR_W'(33);
        end else begin
            c = CHAR_W'(109) + dx - CHAR_W'(44);
        end
        return c;
    endfunction

endpackage

[rtl/b58enc_dp.sv]
// Datapath: bit store, chunked divide by 58, digit shift register and output register.
`timescale 1ns / 1ps

module b58enc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b58enc_pkg::t_in_item i_in_item,
    input  b58enc_pkg::t_dp_cmd  i_cmd,
    output b58enc_pkg::t_dp_sts  o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output b58enc_pkg::t_out_item o_out_item
);
    import b58enc_pkg::*;

    logic [STORE_W-1:0] r_store, n_store;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_pend, n_pend;
    logic [QUO_W-1:0]   r_quo;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIGIT_W-1:0] r_dig [DIGITS];
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [STORE_W-1:0] byte_ext;
    logic [STORE_W-1:0] merged;
    logic [FILL_W-1:0]  fill8;
    logic [FILL_W-1:0]  fill_rem;
    logic               blk;

    logic [PART_W-1:0]         part;
    logic [2*PART_W-1:0]       prod;
    logic [CHUNK_W-1:0]        q_est;
    logic [PART_W-1:0]         q58;
    logic [PART_W-1:0]         r_est;
    logic [CHUNK_W-1:0]        q_fix;
    logic [DIGIT_W-1:0]        r_fix;

    assign byte_ext = STORE_W'(i_in_item.data_byte);
    assign merged   = r_store | (byte_ext << r_fill);
    assign fill8    = r_fill + FILL_W'(8);
    assign blk      = fill8 >= FILL_W'(BLOCK_BITS);
    assign fill_rem = fill8 - FILL_W'(BLOCK_BITS);

    // Store update on accept and on tail load.
    always_comb begin
        n_store = r_store;
        n_fill  = r_fill;
        n_pend  = r_pend;
        if (i_cmd.accept) begin
            if (blk) begin
                n_store = merged >> BLOCK_BITS;
                n_fill  = fill_rem;
                n_pend  = i_in_item.is_final && (fill_rem != '0);
            end else if (i_in_item.is_final) begin
                n_store = '0;
                n_fill  = '0;
                n_pend  = 1'b0;
            end else begin
                n_store = merged;
                n_fill  = fill8;
            end
        end else if (i_cmd.load_pend) begin
            n_store = '0;
            n_fill  = '0;
            n_pend  = 1'b0;
        end
    end

    // One divide step: (rem:chunk) / 58 via reciprocal, one correction.
    always_comb begin
        part  = {r_rem, r_quo[QUO_W-1 -: CHUNK_W]};
        prod  = (2*PART_W)'(part) * (2*PART_W)'(RECIP);
        q_est = prod[RECIP_SHIFT +: CHUNK_W];
        q58   = (PART_W'(q_est) << 6) - (PART_W'(q_est) << 2) - (PART_W'(q_est) << 1);
        r_est = part - q58;
        if (r_est >= PART_W'(RADIX)) begin
            q_fix = q_est + CHUNK_W'(1);
            r_fix = DIGIT_W'(r_est - PART_W'(RADIX));
        end else begin
            q_fix = q_est;
            r_fix = DIGIT_W'(r_est);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store     <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_store <= n_store;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_quo <= QUO_W'(merged[BLOCK_BITS-1:0]);
            r_rem <= '0;
        end else if (i_cmd.load_pend) begin
            r_quo <= QUO_W'(r_store[BLOCK_BITS-1:0]);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-CHUNK_W-1:0], q_fix};
            r_rem <= i_cmd.dig_done ? '0 : r_fix;
        end
    end

    // Digits arrive least significant first; shift up so the top digit lands at 0.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && i_cmd.dig_done) begin
            r_dig[0] <= r_fix;
            for (int i = 1; i < DIGITS; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < DIGITS - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
            r_dig[DIGITS-1] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.out_char <= b58_char(r_dig[0]);
            r_out_item.run_end  <= i_cmd.emit_last;
        end
    end

    assign o_sts.blk_go   = blk || i_in_item.is_final;
    assign o_sts.pend     = r_pend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BLOCK_BITS - 1))
        else $error("bit fill out of range");

    a_store_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_store >> r_fill) == '0)
        else $error("bit store has bits above fill");

    a_pend_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_fill != '0))
        else $error("tail block pending with empty store");

endmodule

[rtl/b58enc_ctrl.sv]
// Controller: sequences accept, divide steps and character emission.
`timescale 1ns / 1ps

module b58enc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b58enc_pkg::t_dp_sts i_sts,
    output b58enc_pkg::t_dp_cmd o_cmd
);
    import b58enc_pkg::*;

    t_state                 r_state, n_state;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    logic [DIG_IDX_W-1:0]   r_digit;
    logic [DIG_IDX_W-1:0]   r_char;

    logic last_chunk;
    logic last_digit;
    logic last_char;

    assign last_chunk = r_chunk == CHUNK_IDX_W'(CHUNKS - 1);
    assign last_digit = r_digit == DIG_IDX_W'(DIGITS - 1);
    assign last_char  = r_char == DIG_IDX_W'(DIGITS - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.blk_go) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (last_chunk && last_digit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free && last_char) begin
                    n_state = i_sts.pend ? ST_DIV : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.dig_done = last_chunk;
            end
            ST_EMIT: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_last = i_sts.out_free && last_char && !i_sts.pend;
                o_cmd.load_pend = i_sts.out_free && last_char && i_sts.pend;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chunk <= '0;
            r_digit <= '0;
            r_char  <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.div_step) begin
                r_chunk <= last_chunk ? '0 : r_chunk + CHUNK_IDX_W'(1);
                if (last_chunk) begin
                    r_digit <= last_digit ? '0 : r_digit + DIG_IDX_W'(1);
                end
            end
            if (o_cmd.emit) begin
                r_char <= last_char ? '0 : r_char + DIG_IDX_W'(1);
            end
        end
    end

    a_counters_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_chunk == '0 && r_digit == '0 && r_char == '0))
        else $error("counters not cleared while idle");

    a_tail_needs_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_state == ST_DIV) |-> i_sts.pend)
        else $error("second block started without a pending tail");

    a_run_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_last |=> (r_state == ST_IDLE))
        else $error("run ended but controller not idle");

endmodule

[rtl/base58_41bit_chunk_encoder_unit.sv]
// Top level of the base-58 encoder over 41-bit blocks of a byte stream.
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+-----------------------
//  in      | i_in_valid, o_in_ready, i_in_item | sink      | data_byte, is_final
//  out     | o_out_valid, i_out_ready, o_out_item | source | out_char, run_end
//
// One item at a time. A non-final item that completes no block is only merged into the store.
// Each 41-bit block is divided (4 twelve-bit steps of the shared divide-by-58
// unit per digit, 7 digits) and then its 7 characters are emitted.
// A final item that completes a block and leaves bits is followed by a zero-padded tail block.
// Reset is synchronous; output stalls hold emission.
`timescale 1ns / 1ps

module base58_41bit_chunk_encoder_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  b58enc_pkg::t_in_item   i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output b58enc_pkg::t_out_item  o_out_item
);
    import b58enc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    b58enc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    b58enc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[verif/base58_41bit_chunk_encoder_unit_tb.sv]
// Self-checking testbench for the base-58 encoder over 41-bit blocks of a byte stream.
`timescale 1ns / 1ps

module base58_41bit_chunk_encoder_unit_tb;

    import b58enc_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles with no item moving on either side
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_TAIL  = 40;
    localparam int RUN_ITEMS   = 250;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;

    string      b58_alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    t_in_item   byte_queue [$];
    t_out_item  expected_chars [$];
    logic [STORE_W-1:0] pend_bits = '0;
    int         pend_count   = 0;

    int         total_items  = 0;
    int         items_taken  = 0;
    int         chars_seen   = 0;
    int         err_count    = 0;
    int         idle_cycles  = 0;
    logic       in_taken     = 1'b0;
    logic       quiet        = 1'b0;

    int         src_gap      = 0;
    int         sink_gap     = 0;
    int         hold_left    = 0;
    logic       held_once    = 1'b0;

    base58_41bit_chunk_encoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Append one byte to the pending bit stream and queue the characters it completes.
    task automatic predict_chars(input t_in_item it);
        t_out_item        batch [14];
        logic [40:0]      blocks [2];
        int               n_blk;
        longint unsigned  v;
        n_blk      = 0;
        pend_bits  = pend_bits | (STORE_W'(it.data_byte) << pend_count);
        pend_count = pend_count + 8;
        if (pend_count >= BLOCK_BITS) begin
            blocks[n_blk] = pend_bits[40:0];
            n_blk++;
            pend_bits  = pend_bits >> BLOCK_BITS;
            pend_count = pend_count - BLOCK_BITS;
        end
        if (it.is_final) begin
            // pad the leftover bits with zeros and flush them as one more block
            if (pend_count > 0) begin
                blocks[n_blk] = pend_bits[40:0];
                n_blk++;
            end
            pend_bits  = '0;
            pend_count = 0;
        end
        for (int b = 0; b < n_blk; b++) begin
            v = 64'(blocks[b]);
            for (int k = DIGITS - 1; k >= 0; k--) begin
                batch[b * DIGITS + k].out_char = CHAR_W'(b58_alphabet[int'(v % RADIX)]);
                batch[b * DIGITS + k].run_end  = 1'b0;
                v = v / RADIX;
            end
        end
        if (n_blk > 0) begin
            batch[n_blk * DIGITS - 1].run_end = 1'b1;
        end
        for (int j = 0; j < n_blk * DIGITS; j++) begin
            expected_chars.push_back(batch[j]);
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic fin);
        t_in_item it;
        it.data_byte = data;
        it.is_final  = fin;
        byte_queue.push_back(it);
        total_items++;
    endtask

    // Sender: hold the item until it is taken, then offer the next one or idle.
    always @(negedge i_clk) begin : drive_bytes
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item  = i_in_item;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            nxt_valid = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (byte_queue.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 10) - 1;
                end else begin
                    nxt_valid = 1'b1;
                    nxt_item  = byte_queue.pop_front();
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_item  <= nxt_item;
    end

    // Receiver: random stall bursts, plus one long hold-off to back up the block.
    always @(negedge i_clk) begin : drive_ready
        logic nxt_rdy;
        nxt_rdy = 1'b1;
        if (!i_rst_n) begin
            nxt_rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_rdy = 1'b0;
        end else if (!held_once && chars_seen >= 60) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD - 1;
            nxt_rdy   = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            nxt_rdy = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(1, 10) - 1;
            nxt_rdy  = 1'b0;
        end
        i_out_ready <= nxt_rdy;
    end

    always @(posedge i_clk) begin : watch_ports
        t_out_item want;
        logic      out_taken;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (in_taken) begin
            predict_chars(i_in_item);
            items_taken++;
            quiet = (items_taken >= total_items - QUIET_TAIL);
        end
        if (out_taken) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected item, expected none, got char %0d run_end %0b",
                         $time, o_out_item.out_char, o_out_item.run_end);
            end else begin
                want = expected_chars.pop_front();
                if (o_out_item.out_char !== want.out_char) begin
                    err_count++;
                    $display("%0t ns: out_char mismatch, expected %0d, got %0d",
                             $time, want.out_char, o_out_item.out_char);
                end
                if (o_out_item.run_end !== want.run_end) begin
                    err_count++;
                    $display("%0t ns: run_end mismatch, expected %0b, got %0b",
                             $time, want.run_end, o_out_item.run_end);
                end
            end
        end
        if (!i_rst_n || in_taken || out_taken) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("** base58_41bit_chunk_encoder_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int         run_len;
        int         pattern;
        logic [7:0] data;

        // single-byte messages at both extremes
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        // all ones: a full block plus a padded tail from the same byte
        for (int i = 0; i < 6; i++) begin
            queue_byte(8'hFF, i == 5);
        end
        // 40 zero bits padded to a block
        for (int i = 0; i < 5; i++) begin
            queue_byte(8'h00, i == 4);
        end
        // 41 bytes end exactly on a block boundary, so no padded block follows
        for (int i = 0; i < 41; i++) begin
            queue_byte(8'($urandom_range(0, 255)), i == 40);
        end

        while (total_items < RUN_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       run_len = 41;
                1:       run_len = 82;
                2:       run_len = $urandom_range(1, 6);
                default: run_len = $urandom_range(1, 30);
            endcase
            // trim the last message so the run stops at the item budget
            if (run_len > RUN_ITEMS - total_items) begin
                run_len = RUN_ITEMS - total_items;
            end
            pattern = $urandom_range(0, 7);
            for (int i = 0; i < run_len; i++) begin
                if (pattern == 0) begin
                    data = 8'hFF;
                end else if (pattern == 1) begin
                    data = 8'h00;
                end else begin
                    data = 8'($urandom_range(0, 255));
                end
                queue_byte(data, i == run_len - 1);
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items) @(negedge i_clk);
        while (expected_chars.size() > 0) @(negedge i_clk);
        // drain: a flushing item can emit two blocks of characters
        repeat (100) @(negedge i_clk);

        if (err_count == 0 && expected_chars.size() == 0) begin
            $display("** base58_41bit_chunk_encoder_unit: PASSED **");
        end else begin
            $display("** base58_41bit_chunk_encoder_unit: FAILED **");
        end
        $finish;
    end

endmodule

[base58_41bit_chunk_encoder_unit.f]
rtl/b58enc_pkg.sv
rtl/b58enc_dp.sv
rtl/b58enc_ctrl.sv
rtl/base58_41bit_chunk_encoder_unit.sv
verif/base58_41bit_chunk_encoder_unit_tb.sv
